FILE: design/tgr_pkg.sv
package tgr_pkg;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_NONKEY = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] BTN_TAP   = 2'd0;
    localparam logic [1:0] BTN_TAP2  = 2'd1;
    localparam logic [1:0] BTN_HOLD  = 2'd2;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_CLICK   = 2'd1;
    localparam logic [1:0] KIND_PRESS   = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    localparam logic [1:0] GEST_TAP  = 2'd0;
    localparam logic [1:0] GEST_DTAP = 2'd1;
    localparam logic [1:0] GEST_TAP2 = 2'd2;
    localparam logic [1:0] GEST_HOLD = 2'd3;

    localparam int WINDOW_RESET = 250;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] button;
        logic       press;
        logic       tap_bound;
        logic       dtap_bound;
        logic       tap2_bound;
        logic       hold_bound;
        logic [7:0] key_position;
    } t_item;

    typedef struct packed {
        logic       consumed;
        logic [1:0] fire_kind;
        logic [1:0] gesture;
        logic [7:0] fire_position;
    } t_result;

endpackage

FILE: design/tap_gesture_remapper.sv
// An accepted item goes through the input register, then the result register,
// before its result shows on the outputs.
// Throughput: one item per cycle while o_stall is low; ticks that give no result leave the output alone.
// A result held by a stalled output stalls the input only once the next item has one too.
// Reset (synchronous, active low) clears all gesture state and sets the window to 250.
module tap_gesture_remapper #(
    parameter int WINDOW_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_operation,
    input  logic [1:0]             i_button,
    input  logic                   i_press,
    input  logic                   i_tap_bound,
    input  logic                   i_dtap_bound,
    input  logic                   i_tap2_bound,
    input  logic                   i_hold_bound,
    input  logic [7:0]             i_key_position,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [WINDOW_BITS-1:0] i_cfg_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_consumed,
    output logic [1:0]             o_fire_kind,
    output logic [1:0]             o_gesture,
    output logic [7:0]             o_fire_position
);

    logic                   r_in_valid;
    tgr_pkg::t_item         r_in;
    logic                   r_out_valid;
    tgr_pkg::t_result       r_out;
    logic [WINDOW_BITS-1:0] r_window;

    logic             w_has_result;
    tgr_pkg::t_result w_result;
    logic             w_out_free;
    logic             w_advance;
    logic             w_accept;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_advance   = r_in_valid && (!w_has_result || w_out_free);
    assign o_stall     = r_in_valid && !w_advance;
    assign w_accept    = i_valid && !o_stall;

    tgr_core #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_advance),
        .i_item      (r_in),
        .i_window    (r_window),
        .o_has_result(w_has_result),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_BITS'(tgr_pkg::WINDOW_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.operation    <= i_operation;
            r_in.button       <= i_button;
            r_in.press        <= i_press;
            r_in.tap_bound    <= i_tap_bound;
            r_in.dtap_bound   <= i_dtap_bound;
            r_in.tap2_bound   <= i_tap2_bound;
            r_in.hold_bound   <= i_hold_bound;
            r_in.key_position <= i_key_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_consumed      = r_out.consumed;
    assign o_fire_kind     = r_out.fire_kind;
    assign o_gesture       = r_out.gesture;
    assign o_fire_position = r_out.fire_position;

    a_nofire_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fire_kind == tgr_pkg::KIND_NONE |-> o_gesture == tgr_pkg::GEST_TAP
            && o_fire_position == 8'd0)
        else $error("result with no fire carries gesture data");

    a_unconsumed_fire_is_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_consumed && o_fire_kind != tgr_pkg::KIND_NONE
            |-> o_fire_kind == tgr_pkg::KIND_CLICK && o_gesture == tgr_pkg::GEST_TAP)
        else $error("unexpected fire on a pass-through result");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("input register lost an unprocessed item");

    a_blocked_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_has_result && !w_out_free |=> r_out_valid)
        else $error("result register dropped a pending result");

endmodule

FILE: design/tgr_core.sv
module tgr_core #(
    parameter int WINDOW_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  tgr_pkg::t_item         i_item,
    input  logic [WINDOW_BITS-1:0] i_window,
    output logic                   o_has_result,
    output tgr_pkg::t_result       o_result
);

    logic                   r_own_tap, r_own_tap2, r_own_hold;
    logic                   r_pending_tap, r_pending_fires;
    logic [7:0]             r_deferred_position;
    logic [WINDOW_BITS-1:0] r_elapsed;

    logic                   n_own_tap, n_own_tap2, n_own_hold;
    logic                   n_pending_tap, n_pending_fires;
    logic [7:0]             n_deferred_position;
    logic [WINDOW_BITS-1:0] n_elapsed;

    logic [WINDOW_BITS-1:0] w_win;
    logic [WINDOW_BITS-1:0] w_elapsed_inc;

    // A window of zero behaves as a window of one tick.
    assign w_win = (i_window == '0) ? WINDOW_BITS'(1) : i_window;
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + WINDOW_BITS'(1);

    always_comb begin
        n_own_tap           = r_own_tap;
        n_own_tap2          = r_own_tap2;
        n_own_hold          = r_own_hold;
        n_pending_tap       = r_pending_tap;
        n_pending_fires     = r_pending_fires;
        n_deferred_position = r_deferred_position;
        n_elapsed           = r_elapsed;
        o_has_result        = 1'b1;
        o_result            = '0;

        case (i_item.operation)
            tgr_pkg::OP_TICK: begin
                o_has_result = 1'b0;
                if (r_pending_tap) begin
                    n_elapsed = w_elapsed_inc;
                    if (w_elapsed_inc >= w_win) begin
                        n_pending_tap = 1'b0;
                        n_elapsed     = '0;
                        if (r_pending_fires) begin
                            o_has_result           = 1'b1;
                            o_result.fire_kind     = tgr_pkg::KIND_CLICK;
                            o_result.gesture       = tgr_pkg::GEST_TAP;
                            o_result.fire_position = r_deferred_position;
                        end
                    end
                end
            end
            tgr_pkg::OP_KEY: begin
                case (i_item.button)
                    tgr_pkg::BTN_TAP: begin
                        if (!i_item.press) begin
                            o_result.consumed = r_own_tap;
                            n_own_tap         = 1'b0;
                        end else if (!i_item.tap_bound && !i_item.dtap_bound) begin
                            n_own_tap = 1'b0;
                        end else begin
                            n_own_tap         = 1'b1;
                            o_result.consumed = 1'b1;
                            if (!i_item.dtap_bound) begin
                                o_result.fire_kind     = tgr_pkg::KIND_CLICK;
                                o_result.gesture       = tgr_pkg::GEST_TAP;
                                o_result.fire_position = i_item.key_position;
                            end else if (r_pending_tap && r_elapsed < w_win) begin
                                // Second tap inside the window.
                                n_pending_tap          = 1'b0;
                                n_elapsed              = '0;
                                o_result.fire_kind     = tgr_pkg::KIND_CLICK;
                                o_result.gesture       = tgr_pkg::GEST_DTAP;
                                o_result.fire_position = i_item.key_position;
                            end else begin
                                n_pending_tap       = 1'b1;
                                n_pending_fires     = i_item.tap_bound;
                                n_deferred_position = i_item.key_position;
                                n_elapsed           = '0;
                            end
                        end
                    end
                    tgr_pkg::BTN_TAP2: begin
                        if (i_item.press) begin
                            n_own_tap2 = i_item.tap2_bound;
                            if (i_item.tap2_bound) begin
                                o_result.consumed      = 1'b1;
                                o_result.fire_kind     = tgr_pkg::KIND_CLICK;
                                o_result.gesture       = tgr_pkg::GEST_TAP2;
                                o_result.fire_position = i_item.key_position;
                            end
                        end else begin
                            o_result.consumed = r_own_tap2;
                            n_own_tap2        = 1'b0;
                        end
                    end
                    tgr_pkg::BTN_HOLD: begin
                        if (i_item.press) begin
                            n_own_hold = i_item.hold_bound;
                            if (i_item.hold_bound) begin
                                o_result.consumed      = 1'b1;
                                o_result.fire_kind     = tgr_pkg::KIND_PRESS;
                                o_result.gesture       = tgr_pkg::GEST_HOLD;
                                o_result.fire_position = i_item.key_position;
                            end
                        end else if (r_own_hold) begin
                            n_own_hold        = 1'b0;
                            o_result.consumed = 1'b1;
                            // The release fires only while the binding still exists.
                            if (i_item.hold_bound) begin
                                o_result.fire_kind     = tgr_pkg::KIND_RELEASE;
                                o_result.gesture       = tgr_pkg::GEST_HOLD;
                                o_result.fire_position = i_item.key_position;
                            end
                        end
                    end
                    default: begin
                        o_result = '0;
                    end
                endcase
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_tap           <= 1'b0;
            r_own_tap2          <= 1'b0;
            r_own_hold          <= 1'b0;
            r_pending_tap       <= 1'b0;
            r_pending_fires     <= 1'b0;
            r_deferred_position <= '0;
            r_elapsed           <= '0;
        end else if (i_fire) begin
            r_own_tap           <= n_own_tap;
            r_own_tap2          <= n_own_tap2;
            r_own_hold          <= n_own_hold;
            r_pending_tap       <= n_pending_tap;
            r_pending_fires     <= n_pending_fires;
            r_deferred_position <= n_deferred_position;
            r_elapsed           <= n_elapsed;
        end
    end

    a_idle_elapsed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending_tap |-> r_elapsed == '0)
        else $error("elapsed count nonzero with no tap pending");

    a_dtap_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.gesture == tgr_pkg::GEST_DTAP
            && o_result.fire_kind == tgr_pkg::KIND_CLICK |=> !r_pending_tap)
        else $error("double tap left a tap pending");

    a_tick_no_consume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.operation == tgr_pkg::OP_TICK |-> !o_result.consumed)
        else $error("tick produced a consumed result");

endmodule
